// ===== src/gne_pkg.sv =====
// package for the gate netlist evaluator: sizes, codes, payload types, gate function
`default_nettype none

package gne_pkg;

    localparam int MAX_GATES  = 12;
    localparam int MAX_INPUTS = 3;
    localparam int SIG_COUNT  = MAX_INPUTS + MAX_GATES;

    localparam int SIG_W      = 4;
    localparam int GID_W      = 4;
    localparam int CNT_W      = 4;
    localparam int ROW_W      = 3;
    localparam int N_W        = 2;
    localparam int LIVE_W     = 5;
    localparam int KIND_W     = 3;
    localparam int CMD_W      = 3;
    localparam int PALETTE_W  = 6;
    localparam int TARGET_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [N_W-1:0]       INPUT_COUNT_RESET = 2'd2;
    localparam logic [PALETTE_W-1:0] PALETTE_RESET     = 6'h0f;
    localparam logic [TARGET_W-1:0]  TARGET_RESET      = 8'h08;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_PROBE  = 3'd3,
        CMD_EVAL   = 3'd4,
        CMD_CHECK  = 3'd5
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOT  = 3'd0,
        KIND_AND  = 3'd1,
        KIND_OR   = 3'd2,
        KIND_XOR  = 3'd3,
        KIND_NAND = 3'd4,
        KIND_NOR  = 3'd5
    } gate_kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_EMPTY  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_COUNT = 2'd0,
        CFG_PALETTE     = 2'd1,
        CFG_TARGET      = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_TEST,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KIND_W-1:0] gate_kind;
        logic [SIG_W-1:0]  first_source;
        logic [SIG_W-1:0]  second_source;
        logic [SIG_W-1:0]  probe_index;
        logic [ROW_W-1:0]  row;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             bit_value;
        logic [GID_W-1:0] new_gate_id;
        logic [CNT_W-1:0] gate_count;
    } rsp_t;

    function automatic logic gate_eval(logic [KIND_W-1:0] kind, logic a, logic b);
        logic y;
        case (kind)
            KIND_NOT:  y = ~a;
            KIND_AND:  y = a & b;
            KIND_OR:   y = a | b;
            KIND_XOR:  y = a ^ b;
            KIND_NAND: y = ~(a & b);
            KIND_NOR:  y = ~(a | b);
            default:   y = 1'b0;
        endcase
        return y;
    endfunction

    // primary input values of one row, first input on the row's top bit
    function automatic logic [MAX_INPUTS-1:0] input_bits(logic [ROW_W-1:0] r,
                                                         logic [N_W-1:0] n);
        logic [MAX_INPUTS-1:0] v;
        logic [N_W-1:0]        pos;
        v = '0;
        for (int i = 0; i < MAX_INPUTS; i++)
        begin
            pos = n - N_W'(1) - N_W'(i);
            if (N_W'(i) < n)
            begin
                v[i] = r[pos];
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/gate_netlist_evaluator_top.sv =====
// top level of the gate netlist evaluator: command decode, gate store and sweep sequencer
`default_nettype none

// Gate netlist evaluator. Holds an ordered list of up to twelve two-input
// gates, each fed by primary inputs or earlier gates, and runs one command
// per request transfer: add, remove last, clear, probe a signal on a row,
// evaluate the last gate on a row, or check the last gate against the
// target truth table. One gate evaluation unit walks the list, one gate per
// cycle, writing each output into a signal register. Add, remove, clear and
// every rejected or empty case go straight to the response; probe and eval
// sweep every gate present once, and check sweeps the list once per row
// tried, stopping at the first mismatch, with up to 2^input_count rows. The
// response then sits in its own register until its transfer, and the block
// takes the next request in the cycle after that. Configuration writes
// (input_count, palette_mask, target_table) are taken at any cycle the
// write enable is high and are expected only while the block is idle.
module gate_netlist_evaluator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire gne_pkg::req_t               req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output gne_pkg::rsp_t                    rsp,
    input  wire logic                        cfg_we,
    input  wire logic [gne_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gne_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gne_pkg::*;

    // configuration registers
    logic [N_W-1:0]       input_count_reg;
    logic [PALETTE_W-1:0] palette_reg;
    logic [TARGET_W-1:0]  target_reg;

    // sequencer and datapath registers
    seq_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SIG_COUNT-1:0] sig_reg, sig_next;
    logic [GID_W-1:0]     k_reg, k_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [SIG_W-1:0]     probe_reg, probe_next;
    rsp_t                 rsp_reg, rsp_next;

    // gate store, written on add only
    logic [KIND_W-1:0]    type_mem [MAX_GATES];
    logic [SIG_W-1:0]     src1_mem [MAX_GATES];
    logic [SIG_W-1:0]     src2_mem [MAX_GATES];
    logic                 store_we;
    logic [SIG_W-1:0]     store_src2;

    // derived values
    logic [N_W-1:0]       n_eff;
    logic [LIVE_W-1:0]    live;
    logic [ROW_W:0]       rows_span;
    logic [ROW_W-1:0]     last_row;
    logic [ROW_W-1:0]     req_row;

    // decode of the offered request
    logic                 accept;
    logic                 add_ok;
    logic                 sweep_cmd;
    logic [SIG_W-1:0]     src2_eff;
    logic [TARGET_W-1:0]  palette_ext;

    // shared gate unit
    logic [LIVE_W-1:0]    own_idx;
    logic [SIG_W-1:0]     sa, sb;
    logic                 op_a, op_b, gate_out;

    // end of sweep compare
    logic [SIG_W-1:0]     out_idx;
    logic                 out_sig, want, match;
    logic                 last_gate;
    logic                 more_rows;

    // input count saturates into 1..MAX_INPUTS
    always_comb
    begin
        if (input_count_reg == N_W'(0))
        begin
            n_eff = N_W'(1);
        end
        else if (input_count_reg > N_W'(MAX_INPUTS))
        begin
            n_eff = N_W'(MAX_INPUTS);
        end
        else
        begin
            n_eff = input_count_reg;
        end
    end

    assign live      = LIVE_W'(n_eff) + LIVE_W'(count_reg);
    assign rows_span = ((ROW_W + 1)'(1) << n_eff) - (ROW_W + 1)'(1);
    assign last_row  = rows_span[ROW_W-1:0];
    assign req_row   = (req.row > last_row) ? last_row : req.row;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    // add checks: known kind, in palette, room left, sources already defined
    assign palette_ext = TARGET_W'(palette_reg);
    assign src2_eff    = (req.gate_kind == KIND_NOT) ? req.first_source : req.second_source;
    assign add_ok      = (req.gate_kind <= KIND_NOR)
                      && palette_ext[req.gate_kind]
                      && (count_reg < CNT_W'(MAX_GATES))
                      && (LIVE_W'(req.first_source) < live)
                      && (LIVE_W'(src2_eff) < live);

    always_comb
    begin
        case (req.cmd)
            CMD_PROBE: sweep_cmd = (LIVE_W'(req.probe_index) < live);
            CMD_EVAL:  sweep_cmd = (count_reg != CNT_W'(0));
            CMD_CHECK: sweep_cmd = (count_reg != CNT_W'(0));
            default:   sweep_cmd = 1'b0;
        endcase
    end

    // shared gate unit: evaluates gate k_reg; a source at or above its own index reads 0
    assign own_idx  = LIVE_W'(n_eff) + LIVE_W'(k_reg);
    assign sa       = src1_mem[k_reg];
    assign sb       = src2_mem[k_reg];
    assign op_a     = (LIVE_W'(sa) < own_idx) ? sig_reg[sa] : 1'b0;
    assign op_b     = (LIVE_W'(sb) < own_idx) ? sig_reg[sb] : 1'b0;
    assign gate_out = gate_eval(type_mem[k_reg], op_a, op_b);

    assign last_gate = (k_reg == GID_W'(count_reg - CNT_W'(1)));

    // last gate output against the target row
    assign out_idx   = SIG_W'(live - LIVE_W'(1));
    assign out_sig   = sig_reg[out_idx];
    assign want      = target_reg[row_reg];
    assign match     = (out_sig == want);
    assign more_rows = (cmd_reg == CMD_CHECK) && match && (row_reg != last_row);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!sweep_cmd)
                    begin
                        state_next = S_RESP;
                    end
                    else if (count_reg == CNT_W'(0))
                    begin
                        state_next = S_TEST;
                    end
                    else
                    begin
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (last_gate)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                state_next = more_rows ? S_SWEEP : S_RESP;
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next = count_reg;
        sig_next   = sig_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        cmd_next   = cmd_reg;
        probe_next = probe_reg;
        rsp_next   = rsp_reg;
        store_we   = 1'b0;
        store_src2 = src2_eff;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.cmd;
                    probe_next = req.probe_index;
                    row_next   = (req.cmd == CMD_CHECK) ? ROW_W'(0) : req_row;
                    k_next     = GID_W'(0);
                    sig_next[MAX_INPUTS-1:0] = input_bits(
                        (req.cmd == CMD_CHECK) ? ROW_W'(0) : req_row, n_eff);

                    rsp_next.status      = STAT_OK;
                    rsp_next.bit_value   = 1'b0;
                    rsp_next.new_gate_id = GID_W'(0);
                    case (req.cmd)
                        CMD_ADD:
                        begin
                            if (add_ok)
                            begin
                                store_we             = 1'b1;
                                rsp_next.new_gate_id = GID_W'(count_reg);
                                count_next           = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                rsp_next.status = STAT_REJECT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == CNT_W'(0))
                            begin
                                rsp_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = CNT_W'(0);
                        end
                        CMD_PROBE:
                        begin
                            if (!sweep_cmd)
                            begin
                                rsp_next.status = STAT_REJECT;
                            end
                        end
                        CMD_EVAL, CMD_CHECK:
                        begin
                            if (!sweep_cmd)
                            begin
                                rsp_next.status = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_REJECT;
                        end
                    endcase
                    rsp_next.gate_count = count_next;
                end
            end
            S_SWEEP:
            begin
                sig_next[own_idx[SIG_W-1:0]] = gate_out;
                k_next = k_reg + GID_W'(1);
            end
            S_TEST:
            begin
                case (cmd_reg)
                    CMD_PROBE: rsp_next.bit_value = sig_reg[probe_reg];
                    CMD_EVAL:  rsp_next.bit_value = out_sig;
                    CMD_CHECK: rsp_next.bit_value = match;
                    default:   rsp_next.bit_value = 1'b0;
                endcase
                if (more_rows)
                begin
                    row_next = row_reg + ROW_W'(1);
                    k_next   = GID_W'(0);
                    sig_next[MAX_INPUTS-1:0] = input_bits(row_reg + ROW_W'(1), n_eff);
                end
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp       = rsp_reg;

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            input_count_reg <= INPUT_COUNT_RESET;
            palette_reg     <= PALETTE_RESET;
            target_reg      <= TARGET_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INPUT_COUNT: input_count_reg <= cfg_data[N_W-1:0];
                    CFG_PALETTE:     palette_reg     <= cfg_data[PALETTE_W-1:0];
                    CFG_TARGET:      target_reg      <= cfg_data[TARGET_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        sig_reg   <= sig_next;
        k_reg     <= k_next;
        row_reg   <= row_next;
        cmd_reg   <= cmd_next;
        probe_reg <= probe_next;
        rsp_reg   <= rsp_next;
    end

    // gate store write at the next free slot
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            type_mem[count_reg] <= req.gate_kind;
            src1_mem[count_reg] <= req.first_source;
            src2_mem[count_reg] <= store_src2;
        end
    end

`ifndef ASSERT_OFF
    // no request transfer while a response is pending
    a_busy_while_resp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while response pending");

    // gate list never grows past capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_GATES))
        else $error("gate count past capacity");

    // the sweep never walks past the last gate present
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (k_reg < count_reg))
        else $error("sweep index past last gate");

    // the count changes only on the cycle a request transfers
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("gate count changed without a request");
`endif

endmodule

`default_nettype wire
